[rtl/text_console_cursor_writer_assert.svh]
// Assertion macros shared by the console writer modules.
`ifndef TEXT_CONSOLE_CURSOR_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_WRITER_ASSERT_SVH

`ifndef ASSERT_OFF

`define TCCW_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("console writer assertion failed");

`define TCCW_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("console writer forbidden condition seen");

`else

`define TCCW_ASSERT(lbl, clk, rst_n, prop)

`define TCCW_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

[rtl/tccw_pkg.sv]
package tccw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int CHAR_W   = 8;
  localparam int COL_W    = 7;
  localparam int ROW_W    = 5;
  localparam int ADDR_W   = 11;
  localparam int CALC_W   = COL_W + ROW_W;
  localparam int NIBBLE_W = 4;
  localparam int VALUE_W  = 16;

  localparam int TAB_STEP = 8;
  localparam int TAB_BITS = $clog2(TAB_STEP);

  localparam logic [NIBBLE_W-1:0] FG_RESET = 4'hF;
  localparam logic [NIBBLE_W-1:0] BG_RESET = 4'h0;

  localparam logic [CHAR_W-1:0] CHAR_BS        = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_LF        = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR        = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_PRINT_LO  = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_PRINT_HI  = 8'h7F;

  typedef enum logic [0:0] {
    CFG_FG = 1'b0,
    CFG_BG = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic              write_enable;
    logic [ADDR_W-1:0] cell_address;
    logic [VALUE_W-1:0] cell_value;
    logic [ADDR_W-1:0] cursor_position;
  } result_t;

endpackage

[rtl/tccw_cfg.sv]
module tccw_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic [0:0]                    cfg_index,
  input  logic [tccw_pkg::NIBBLE_W-1:0] cfg_data,
  output logic [2*tccw_pkg::NIBBLE_W-1:0] attr
);

  logic [tccw_pkg::NIBBLE_W-1:0] fg_r, fg_nxt;
  logic [tccw_pkg::NIBBLE_W-1:0] bg_r, bg_nxt;

  always_comb begin
    fg_nxt = fg_r;
    bg_nxt = bg_r;
    if (cfg_valid) begin
      unique case (tccw_pkg::cfg_reg_t'(cfg_index))
        tccw_pkg::CFG_FG: fg_nxt = cfg_data;
        tccw_pkg::CFG_BG: bg_nxt = cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= tccw_pkg::FG_RESET;
      bg_r <= tccw_pkg::BG_RESET;
    end else begin
      fg_r <= fg_nxt;
      bg_r <= bg_nxt;
    end
  end

  assign attr = {bg_r, fg_r};

endmodule

[rtl/tccw_cursor.sv]
`include "text_console_cursor_writer_assert.svh"

module tccw_cursor #(
  parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            step,
  input  logic [tccw_pkg::CHAR_W-1:0]     char_code,
  input  logic [2*tccw_pkg::NIBBLE_W-1:0] attr,
  output tccw_pkg::result_t               res
);

  localparam logic [tccw_pkg::COL_W:0]    COLS_LIM = (tccw_pkg::COL_W + 1)'(COLUMNS);
  localparam logic [tccw_pkg::ROW_W:0]    ROWS_LIM = (tccw_pkg::ROW_W + 1)'(ROWS);
  localparam logic [tccw_pkg::ROW_W-1:0]  ROW_LAST = tccw_pkg::ROW_W'(ROWS - 1);
  localparam logic [tccw_pkg::CALC_W-1:0] COLS_MUL = tccw_pkg::CALC_W'(COLUMNS);
  localparam logic [tccw_pkg::COL_W:0]    TAB_ADD  = (tccw_pkg::COL_W + 1)'(tccw_pkg::TAB_STEP);

  logic [tccw_pkg::COL_W-1:0] col_r, col_nxt;
  logic [tccw_pkg::ROW_W-1:0] row_r, row_nxt;

  logic [tccw_pkg::COL_W:0]    col_ext;
  logic [tccw_pkg::COL_W:0]    col_tab;
  logic [tccw_pkg::COL_W:0]    col_step;
  logic [tccw_pkg::ROW_W:0]    row_plus;
  logic [tccw_pkg::ROW_W-1:0]  row_inc;
  logic                        printable;
  logic                        line_feed;
  logic                        wrap;
  logic [tccw_pkg::CALC_W-1:0] addr_now;
  logic [tccw_pkg::CALC_W-1:0] addr_new;

  always_comb begin
    col_ext   = {1'b0, col_r};
    col_tab   = col_ext + TAB_ADD;
    row_plus  = {1'b0, row_r} + (tccw_pkg::ROW_W + 1)'(1);
    row_inc   = (row_plus < ROWS_LIM) ? row_plus[tccw_pkg::ROW_W-1:0] : ROW_LAST;
    printable = (char_code >= tccw_pkg::CHAR_PRINT_LO) &&
                (char_code <= tccw_pkg::CHAR_PRINT_HI);
    line_feed = 1'b0;
    col_step  = col_ext;

    case (char_code)
      tccw_pkg::CHAR_BS: begin
        if (col_r != '0) begin
          col_step = col_ext - (tccw_pkg::COL_W + 1)'(1);
        end
      end
      tccw_pkg::CHAR_TAB: begin
        col_step = {col_tab[tccw_pkg::COL_W:tccw_pkg::TAB_BITS],
                    tccw_pkg::TAB_BITS'(0)};
      end
      tccw_pkg::CHAR_CR: begin
        col_step = '0;
      end
      tccw_pkg::CHAR_LF: begin
        col_step  = '0;
        line_feed = 1'b1;
      end
      default: begin
        if (printable) begin
          col_step = col_ext + (tccw_pkg::COL_W + 1)'(1);
        end
      end
    endcase

    wrap    = (col_step >= COLS_LIM);
    col_nxt = wrap ? '0 : col_step[tccw_pkg::COL_W-1:0];
    row_nxt = (wrap || line_feed) ? row_inc : row_r;

    addr_now = tccw_pkg::CALC_W'(row_r) * COLS_MUL + tccw_pkg::CALC_W'(col_r);
    addr_new = tccw_pkg::CALC_W'(row_nxt) * COLS_MUL + tccw_pkg::CALC_W'(col_nxt);

    res.write_enable    = printable;
    res.cell_address    = printable ? addr_now[tccw_pkg::ADDR_W-1:0] : '0;
    res.cell_value      = printable ? {attr, char_code} : '0;
    res.cursor_position = addr_new[tccw_pkg::ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (step) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  `TCCW_ASSERT(a_col_in_range, clk, rst_n, ({1'b0, col_r} < COLS_LIM))
  `TCCW_ASSERT(a_row_in_range, clk, rst_n, ({1'b0, row_r} < ROWS_LIM))
  `TCCW_NEVER(a_idle_fields_zero, clk, rst_n,
              !res.write_enable && (res.cell_address != '0 || res.cell_value != '0))

endmodule

[rtl/text_console_cursor_writer.sv]
// An accepted input beat passes through the input register, then its result through the output register, to out_.
// Throughput: one character per cycle while out_tready does not hold the output register.
// The cursor logic and its constant multiply sit between input and output registers.
// Reset (rst_n low, synchronous) empties both registers, homes the cursor to
// cell 0 and sets the foreground colour to 15 and the background colour to 0.
`include "text_console_cursor_writer_assert.svh"

module text_console_cursor_writer #(
  parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,  // [7:0] char_code
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [39:0]                   out_tdata, // [10:0] cell_address,
                                                   // [26:11] cell_value,
                                                   // [37:27] cursor_position,
                                                   // [39:38] zero
  output logic                          out_tuser, // [0] write_enable
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [0:0]                    cfg_index,
  input  logic [tccw_pkg::NIBBLE_W-1:0] cfg_data
);

  logic                          in_valid_r;
  logic [tccw_pkg::CHAR_W-1:0]   in_data_r;
  logic                          out_valid_r;
  tccw_pkg::result_t             out_data_r;
  tccw_pkg::result_t             res;
  logic [2*tccw_pkg::NIBBLE_W-1:0] attr;
  logic                          advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  tccw_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .attr      (attr)
  );

  tccw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .char_code (in_data_r),
    .attr      (attr),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_data_r <= '0;
    end else if (in_tready && in_tvalid) begin
      in_data_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_data_r.write_enable;
  assign out_tdata  = {2'b00, out_data_r.cursor_position, out_data_r.cell_value,
                       out_data_r.cell_address};

  `TCCW_ASSERT(a_held_item_kept, clk, rst_n, (in_valid_r && !advance) |=> in_valid_r)
  `TCCW_NEVER(a_stall_without_cause, clk, rst_n, !in_tready && !(in_valid_r && out_valid_r))

endmodule
